>>> hdl/slcfr_pkg.sv
// ----------------------------------------------------------------------------
// slcfr_pkg
// Types, constants and the CRC-16/MODBUS byte step shared by the frame
// receiver modules.
// ----------------------------------------------------------------------------
package slcfr_pkg;

  localparam logic [7:0]  SYNC1_BYTE  = 8'h55;
  localparam logic [7:0]  SYNC2_BYTE  = 8'hAA;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] LEN_SAT     = 16'hFFFF;
  localparam logic [15:0] MAX_LEN_RST = 16'd4096;

  // register index of max_payload_length
  localparam logic        REG_MAX_LEN = 1'b0;

  // result kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_GOOD = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;
  localparam logic [1:0] KIND_LONG = 2'd3;

  // work codes handed from the parser to the result stage
  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_CHECK = 2'd1;
  localparam logic [1:0] OP_LONG  = 2'd2;

  typedef struct packed {
    logic [1:0]  op;
    logic        first;    // first CRC op of frame: start from CRC_INIT
    logic [7:0]  data;     // payload byte, or CRC high byte for a check
    logic [7:0]  crc_lo;   // CRC low byte for a check
    logic [7:0]  cmd;
    logic [15:0] len;
  } op_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/slcfr_front.sv
// ----------------------------------------------------------------------------
// slcfr_front
// Byte parser: sync hunt, header, length check and CRC byte capture. Every
// byte that leads to a result is pushed as one op into the queue.
// ----------------------------------------------------------------------------
module slcfr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_rx_byte,
  input  logic [15:0]        max_len,
  input  logic               q_full,
  output logic               push,
  output slcfr_pkg::op_t     push_op
);

  localparam logic [2:0] PH_SYNC1 = 3'd0;
  localparam logic [2:0] PH_SYNC2 = 3'd1;
  localparam logic [2:0] PH_CMD   = 3'd2;
  localparam logic [2:0] PH_RSVD  = 3'd3;
  localparam logic [2:0] PH_LEN   = 3'd4;
  localparam logic [2:0] PH_DATA  = 3'd5;
  localparam logic [2:0] PH_CRCLO = 3'd6;
  localparam logic [2:0] PH_CRCHI = 3'd7;

  logic [2:0]  phase_r,   phase_nxt;
  logic [1:0]  hcnt_r,    hcnt_nxt;
  logic [7:0]  cmd_r,     cmd_nxt;
  logic [23:0] len_r,     len_nxt;     // first three length bytes
  logic [15:0] flen_r,    flen_nxt;    // accepted frame length
  logic [15:0] remain_r,  remain_nxt;
  logic        first_r,   first_nxt;
  logic [7:0]  crclo_r,   crclo_nxt;

  logic        take;
  logic [31:0] len_full;
  logic        too_long;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;
  assign len_full = {in_rx_byte, len_r};
  assign too_long = (len_full[31:16] != 16'd0) || (len_full[15:0] > max_len);

  always_comb begin
    phase_nxt  = phase_r;
    hcnt_nxt   = hcnt_r;
    cmd_nxt    = cmd_r;
    len_nxt    = len_r;
    flen_nxt   = flen_r;
    remain_nxt = remain_r;
    first_nxt  = first_r;
    crclo_nxt  = crclo_r;
    push       = 1'b0;
    push_op    = '0;
    push_op.first = first_r;
    push_op.cmd   = cmd_r;
    push_op.len   = flen_r;
    push_op.data  = in_rx_byte;
    push_op.crc_lo = crclo_r;
    if (take) begin
      unique case (phase_r)
        PH_SYNC1: begin
          if (in_rx_byte == slcfr_pkg::SYNC1_BYTE) phase_nxt = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (in_rx_byte == slcfr_pkg::SYNC2_BYTE) begin
            phase_nxt = PH_CMD;
          end else if (in_rx_byte != slcfr_pkg::SYNC1_BYTE) begin
            phase_nxt = PH_SYNC1;
          end
        end
        PH_CMD: begin
          cmd_nxt   = in_rx_byte;
          phase_nxt = PH_RSVD;
        end
        PH_RSVD: begin
          hcnt_nxt  = 2'd0;
          len_nxt   = '0;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (hcnt_r != 2'd3) begin
            len_nxt[{hcnt_r, 3'b000} +: 8] = in_rx_byte;
            hcnt_nxt = hcnt_r + 2'd1;
          end else begin
            hcnt_nxt = 2'd0;
            if (too_long) begin
              phase_nxt   = PH_SYNC1;
              push        = 1'b1;
              push_op.op  = slcfr_pkg::OP_LONG;
              push_op.len = (len_full[31:16] != 16'd0) ? slcfr_pkg::LEN_SAT
                                                       : len_full[15:0];
            end else begin
              flen_nxt   = len_full[15:0];
              remain_nxt = len_full[15:0];
              first_nxt  = 1'b1;
              phase_nxt  = (len_full[15:0] != 16'd0) ? PH_DATA : PH_CRCLO;
            end
          end
        end
        PH_DATA: begin
          push       = 1'b1;
          push_op.op = slcfr_pkg::OP_DATA;
          first_nxt  = 1'b0;
          remain_nxt = remain_r - 16'd1;
          if (remain_r == 16'd1) phase_nxt = PH_CRCLO;
        end
        PH_CRCLO: begin
          crclo_nxt = in_rx_byte;
          phase_nxt = PH_CRCHI;
        end
        PH_CRCHI: begin
          push       = 1'b1;
          push_op.op = slcfr_pkg::OP_CHECK;
          phase_nxt  = PH_SYNC1;
        end
        default: phase_nxt = PH_SYNC1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SYNC1;
      hcnt_r   <= 2'd0;
      cmd_r    <= 8'd0;
      len_r    <= '0;
      flen_r   <= 16'd0;
      remain_r <= 16'd0;
      first_r  <= 1'b0;
      crclo_r  <= 8'd0;
    end else begin
      phase_r  <= phase_nxt;
      hcnt_r   <= hcnt_nxt;
      cmd_r    <= cmd_nxt;
      len_r    <= len_nxt;
      flen_r   <= flen_nxt;
      remain_r <= remain_nxt;
      first_r  <= first_nxt;
      crclo_r  <= crclo_nxt;
    end
  end

endmodule

>>> hdl/slcfr_queue.sv
// ----------------------------------------------------------------------------
// slcfr_queue
// Short FIFO of parser ops between the front and the result stage.
// ----------------------------------------------------------------------------
module slcfr_queue #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  slcfr_pkg::op_t push_op,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output slcfr_pkg::op_t head_op
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  slcfr_pkg::op_t mem_r [DEPTH];
  logic [PW-1:0] wptr_r, wptr_nxt;
  logic [PW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] cnt_r,  cnt_nxt;
  logic          do_pop;

  assign full       = (cnt_r == DEPTH_C);
  assign head_valid = (cnt_r != '0);
  assign head_op    = mem_r[rptr_r];
  assign do_pop     = pop && head_valid;

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) wptr_nxt = (wptr_r == LAST) ? '0 : wptr_r + PW'(1);
    if (do_pop) rptr_nxt = (rptr_r == LAST) ? '0 : rptr_r + PW'(1);
    if (push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    else if (!push && do_pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_op;
  end

endmodule

>>> hdl/slcfr_back.sv
// ----------------------------------------------------------------------------
// slcfr_back
// Result stage: runs the payload CRC, checks the received CRC and drives
// the output register.
// ----------------------------------------------------------------------------
module slcfr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  slcfr_pkg::op_t head_op,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [1:0]     out_result_kind,
  output logic [7:0]     out_payload_byte,
  output logic [7:0]     out_frame_command,
  output logic [15:0]    out_frame_length,
  output logic           out_end_of_frame
);

  logic        valid_r;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crc_base;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [7:0]  cmd_r;
  logic [15:0] len_r;
  logic        eof_r, eof_nxt;

  assign pop      = head_valid && (!valid_r || out_ready);
  assign crc_base = head_op.first ? slcfr_pkg::CRC_INIT : crc_r;

  always_comb begin
    crc_nxt  = crc_r;
    kind_nxt = slcfr_pkg::KIND_DATA;
    byte_nxt = 8'd0;
    eof_nxt  = 1'b1;
    case (head_op.op)
      slcfr_pkg::OP_DATA: begin
        crc_nxt  = slcfr_pkg::crc_feed(crc_base, head_op.data);
        byte_nxt = head_op.data;
        eof_nxt  = 1'b0;
      end
      slcfr_pkg::OP_CHECK: begin
        kind_nxt = ({head_op.data, head_op.crc_lo} == crc_base) ? slcfr_pkg::KIND_GOOD
                                                                : slcfr_pkg::KIND_BAD;
      end
      default: kind_nxt = slcfr_pkg::KIND_LONG;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      crc_r   <= slcfr_pkg::CRC_INIT;
    end else begin
      if (pop) begin
        valid_r <= 1'b1;
        crc_r   <= crc_nxt;
      end else if (out_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      cmd_r  <= head_op.cmd;
      len_r  <= head_op.len;
      eof_r  <= eof_nxt;
    end
  end

  assign out_valid         = valid_r;
  assign out_result_kind   = kind_r;
  assign out_payload_byte  = byte_r;
  assign out_frame_command = cmd_r;
  assign out_frame_length  = len_r;
  assign out_end_of_frame  = eof_r;

endmodule

>>> hdl/sync_length_crc16_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_length_crc16_frame_receiver
// Sync/length framed byte stream receiver with CRC-16/MODBUS payload check.
// ----------------------------------------------------------------------------
//  channel  dir  handshake             payload
//  in_      in   in_valid/in_ready     in_rx_byte[7:0]
//  out_     out  out_valid/out_ready   result_kind, payload_byte, frame_command,
//                                      frame_length, end_of_frame
//  cfg_     in   APB psel/penable      paddr[2:0], 32-bit data, pready tied high
//
//  One byte per cycle while the FIFO is not full; the parser places each
//  result-bearing byte in a QUEUE_DEPTH-entry FIFO and the result stage runs
//  the CRC byte step. A result passes through the FIFO and the output register.
//  rst_n is synchronous; no clearing pass is needed after reset.
//  A stalled output backs up through the FIFO; in_ready drops only when full.
// ----------------------------------------------------------------------------
module sync_length_crc16_frame_receiver #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic [7:0]  out_frame_command,
  output logic [15:0] out_frame_length,
  output logic        out_end_of_frame,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [15:0]    max_len_r;
  logic           q_full;
  logic           push;
  slcfr_pkg::op_t push_op;
  logic           pop;
  logic           head_valid;
  slcfr_pkg::op_t head_op;

  // configuration register
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= slcfr_pkg::MAX_LEN_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr[2] == slcfr_pkg::REG_MAX_LEN) begin
      max_len_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == slcfr_pkg::REG_MAX_LEN) ? {16'd0, max_len_r}
                                                               : 32'd0;

  slcfr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .max_len    (max_len_r),
    .q_full     (q_full),
    .push       (push),
    .push_op    (push_op)
  );

  slcfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_op    (push_op),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_op    (head_op)
  );

  slcfr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_valid        (head_valid),
    .head_op           (head_op),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_payload_byte  (out_payload_byte),
    .out_frame_command (out_frame_command),
    .out_frame_length  (out_frame_length),
    .out_end_of_frame  (out_end_of_frame)
  );

endmodule

>>> sim/tb_sync_length_crc16_frame_receiver.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sync_length_crc16_frame_receiver
// Self-checking bench for the sync/length framed receiver. A byte-level
// predictor tracks the frame parser and the CRC-16/MODBUS check and queues
// the expected results. Frames, noise and false starts are driven under
// three handshake pacing modes and several max_payload_length settings.
// ----------------------------------------------------------------------------
module tb_sync_length_crc16_frame_receiver;

  localparam int STALL_LIMIT   = 2000;  // cycles without any transaction
  localparam int SETTLE_CYCLES = 16;
  localparam int SHOWN_ERRORS  = 10;
  localparam logic [2:0] MAX_LEN_ADDR = {slcfr_pkg::REG_MAX_LEN, 2'b00};
  localparam logic [15:0] EMPTY_CRC = slcfr_pkg::CRC_INIT;

  typedef enum logic [2:0] {
    HUNT_SYNC1, HUNT_SYNC2, GET_CMD, SKIP_RSVD,
    GET_LEN, TAKE_DATA, GET_CRC_LO, GET_CRC_HI
  } rx_phase_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  pbyte;
    logic [7:0]  cmd;
    logic [15:0] flen;
    logic        eof;
  } frame_result_t;

  class frame_rx_scoreboard;
    rx_phase_t     phase;
    logic [1:0]    len_idx;
    logic [7:0]    cmd_held;
    logic [31:0]   len_acc;
    logic [15:0]   remaining;
    logic [15:0]   crc_acc;
    logic [7:0]    crc_lo;
    logic [15:0]   max_len;
    frame_result_t expected_results[$];
    int            failures;
    int            rx_bytes;
    int            kind_count[4];

    function new();
      phase     = HUNT_SYNC1;
      len_idx   = '0;
      cmd_held  = '0;
      len_acc   = '0;
      remaining = '0;
      crc_acc   = slcfr_pkg::CRC_INIT;
      crc_lo    = '0;
      max_len   = slcfr_pkg::MAX_LEN_RST;
      failures  = 0;
      rx_bytes  = 0;
      foreach (kind_count[i]) kind_count[i] = 0;
    endfunction

    // bit-serial reflected CRC, LSB of the data first
    static function logic [15:0] crc16_modbus_step(logic [15:0] crc, logic [7:0] d);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int i = 0; i < 8; i++) begin
        fb = c[0] ^ d[i];
        c  = c >> 1;
        if (fb) c = c ^ slcfr_pkg::CRC_POLY;
      end
      return c;
    endfunction

    function void set_max_len(logic [15:0] v);
      max_len = v;
    endfunction

    function void expect_result(logic [1:0] kind, logic [7:0] pbyte, logic [15:0] flen,
                                logic eof);
      frame_result_t e;
      e.kind  = kind;
      e.pbyte = pbyte;
      e.cmd   = cmd_held;
      e.flen  = flen;
      e.eof   = eof;
      expected_results.insert(expected_results.size(), e);
      kind_count[kind]++;
    endfunction

    // one accepted rx byte transaction
    function void predict_rx_byte(logic [7:0] b);
      rx_bytes++;
      case (phase)
        HUNT_SYNC1: begin
          if (b == slcfr_pkg::SYNC1_BYTE) phase = HUNT_SYNC2;
        end
        HUNT_SYNC2: begin
          if (b == slcfr_pkg::SYNC2_BYTE) phase = GET_CMD;
          else if (b != slcfr_pkg::SYNC1_BYTE) phase = HUNT_SYNC1;
        end
        GET_CMD: begin
          cmd_held = b;
          phase    = SKIP_RSVD;
        end
        SKIP_RSVD: begin
          len_idx = '0;
          len_acc = '0;
          phase   = GET_LEN;
        end
        GET_LEN: begin
          len_acc = len_acc | (32'(b) << (8 * len_idx));
          if (len_idx != 2'd3) begin
            len_idx++;
          end else begin
            len_idx = '0;
            if (len_acc > 32'(max_len)) begin
              phase = HUNT_SYNC1;
              expect_result(slcfr_pkg::KIND_LONG, 8'h00,
                            (len_acc > 32'(slcfr_pkg::LEN_SAT)) ? slcfr_pkg::LEN_SAT
                                                                : len_acc[15:0], 1'b1);
            end else begin
              remaining = len_acc[15:0];
              crc_acc   = slcfr_pkg::CRC_INIT;
              phase     = (remaining != 0) ? TAKE_DATA : GET_CRC_LO;
            end
          end
        end
        TAKE_DATA: begin
          crc_acc = crc16_modbus_step(crc_acc, b);
          remaining--;
          if (remaining == 0) phase = GET_CRC_LO;
          expect_result(slcfr_pkg::KIND_DATA, b, len_acc[15:0], 1'b0);
        end
        GET_CRC_LO: begin
          crc_lo = b;
          phase  = GET_CRC_HI;
        end
        default: begin
          phase = HUNT_SYNC1;
          expect_result(({b, crc_lo} == crc_acc) ? slcfr_pkg::KIND_GOOD
                                                 : slcfr_pkg::KIND_BAD, 8'h00,
                        len_acc[15:0], 1'b1);
        end
      endcase
    endfunction

    function void flag(string what);
      failures++;
      if (failures <= SHOWN_ERRORS) $display("ERROR @%0t: %s", $time, what);
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] pbyte, logic [7:0] cmd,
                               logic [15:0] flen, logic eof);
      frame_result_t e;
      string         bad;
      if (expected_results.size() == 0) begin
        flag($sformatf("unexpected result kind=%0d byte=%02h cmd=%02h len=%0d eof=%0b",
                       kind, pbyte, cmd, flen, eof));
        return;
      end
      e   = expected_results.pop_front();
      bad = "";
      if (kind  !== e.kind)  bad = {bad, " kind"};
      if (pbyte !== e.pbyte) bad = {bad, " payload_byte"};
      if (cmd   !== e.cmd)   bad = {bad, " frame_command"};
      if (flen  !== e.flen)  bad = {bad, " frame_length"};
      if (eof   !== e.eof)   bad = {bad, " end_of_frame"};
      if (bad != "")
        flag($sformatf({"field mismatch (%s ): expected kind=%0d byte=%02h cmd=%02h ",
                        "len=%0d eof=%0b, got kind=%0d byte=%02h cmd=%02h len=%0d eof=%0b"},
                       bad, e.kind, e.pbyte, e.cmd, e.flen, e.eof,
                       kind, pbyte, cmd, flen, eof));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void flush_missing();
      frame_result_t e;
      while (expected_results.size() != 0) begin
        e = expected_results.pop_front();
        flag($sformatf("result never arrived: kind=%0d byte=%02h cmd=%02h len=%0d",
                       e.kind, e.pbyte, e.cmd, e.flen));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_result_kind;
  logic [7:0]  out_payload_byte;
  logic [7:0]  out_frame_command;
  logic [15:0] out_frame_length;
  logic        out_end_of_frame;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  frame_rx_scoreboard sb;
  int send_idle_pct = 34;
  int recv_idle_pct = 82;
  int rx_pushed     = 0;

  sync_length_crc16_frame_receiver dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_payload_byte  (out_payload_byte),
    .out_frame_command (out_frame_command),
    .out_frame_length  (out_frame_length),
    .out_end_of_frame  (out_end_of_frame),
    .cfg_psel          (cfg_psel),
    .cfg_penable       (cfg_penable),
    .cfg_pwrite        (cfg_pwrite),
    .cfg_paddr         (cfg_paddr),
    .cfg_pwdata        (cfg_pwdata),
    .cfg_prdata        (cfg_prdata),
    .cfg_pready        (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.predict_rx_byte(in_rx_byte);
      if (out_valid && out_ready)
        sb.check_result(out_result_kind, out_payload_byte, out_frame_command,
                        out_frame_length, out_end_of_frame);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic push_rx_byte(input logic [7:0] b);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    rx_pushed++;
  endtask

  task automatic push_bytes(input logic [7:0] q[$]);
    foreach (q[i]) push_rx_byte(q[i]);
  endtask

  // stop sending, let every expected result drain, then give the parser time to settle
  task automatic go_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_max_length(input logic [15:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= MAX_LEN_ADDR;
    cfg_pwdata  <= 32'(v);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.set_max_len(v);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    if (cfg_prdata !== 32'(v))
      sb.flag($sformatf("max_payload_length readback %08h, wrote %04h", cfg_prdata, v));
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // one random piece of stream: a frame, line noise or a false start
  task automatic send_random_chunk();
    logic [7:0]  chunk[$];
    logic [7:0]  d;
    logic [31:0] len;
    logic [15:0] crc;
    int          pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      // noise never holds 0xAA, so it cannot form a sync pair
      repeat ($urandom_range(1, 6)) begin
        d = 8'($urandom);
        if (d == slcfr_pkg::SYNC2_BYTE) d = d ^ 8'h01;
        chunk.insert(chunk.size(), d);
      end
    end else if (pick < 13) begin
      d = 8'($urandom);
      if (d == slcfr_pkg::SYNC1_BYTE || d == slcfr_pkg::SYNC2_BYTE) d = 8'h00;
      chunk.insert(chunk.size(), slcfr_pkg::SYNC1_BYTE);
      chunk.insert(chunk.size(), d);
    end else begin
      if ($urandom_range(0, 9) == 0) chunk.insert(chunk.size(), slcfr_pkg::SYNC1_BYTE);
      chunk.insert(chunk.size(), slcfr_pkg::SYNC1_BYTE);
      chunk.insert(chunk.size(), slcfr_pkg::SYNC2_BYTE);
      chunk.insert(chunk.size(), 8'($urandom));
      chunk.insert(chunk.size(), 8'($urandom));
      if (pick < 23) begin
        if ($urandom_range(0, 1) == 0)
          len = 32'(sb.max_len) + 32'($urandom_range(0, 500)) + 32'd1;
        else
          len = $urandom | (32'd1 << $urandom_range(16, 31));
      end else begin
        if ($urandom_range(0, 19) == 0) len = $urandom_range(0, 300);
        else len = $urandom_range(0, 12);
        if (len > 32'(sb.max_len)) len = 32'(sb.max_len);
      end
      for (int i = 0; i < 4; i++) chunk.insert(chunk.size(), len[8*i +: 8]);
      if (pick >= 23) begin
        crc = slcfr_pkg::CRC_INIT;
        for (int i = 0; i < int'(len); i++) begin
          d = 8'($urandom);
          chunk.insert(chunk.size(), d);
          crc = frame_rx_scoreboard::crc16_modbus_step(crc, d);
        end
        if ($urandom_range(0, 99) < 15) crc = crc ^ 16'($urandom_range(1, 65535));
        chunk.insert(chunk.size(), crc[7:0]);
        chunk.insert(chunk.size(), crc[15:8]);
      end
    end
    push_bytes(chunk);
  endtask

  task automatic run_random(input int target);
    int start;
    start = rx_pushed;
    while (rx_pushed - start < target) send_random_chunk();
    go_idle();
  endtask

  initial begin
    logic [7:0]  directed[$];
    logic [15:0] crc;
    logic [15:0] narrow_max;
    logic [15:0] wide_max;
    sb = new();
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_rx_byte  <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // false start, zero-length frame behind a repeated sync byte,
    // then a one-byte frame whose CRC is off
    crc = frame_rx_scoreboard::crc16_modbus_step(slcfr_pkg::CRC_INIT, 8'hFF);
    directed = '{slcfr_pkg::SYNC1_BYTE, 8'h12,
                 slcfr_pkg::SYNC1_BYTE, slcfr_pkg::SYNC1_BYTE, slcfr_pkg::SYNC2_BYTE,
                 8'h7E, 8'h5A,
                 8'h00, 8'h00, 8'h00, 8'h00, EMPTY_CRC[7:0], EMPTY_CRC[15:8],
                 slcfr_pkg::SYNC1_BYTE, slcfr_pkg::SYNC2_BYTE, 8'hFF, 8'h00,
                 8'h01, 8'h00, 8'h00, 8'h00, 8'hFF, crc[7:0], crc[15:8] ^ 8'h80};
    push_bytes(directed);
    run_random(250);

    // limit lowered while a header is half received
    directed = '{slcfr_pkg::SYNC1_BYTE, slcfr_pkg::SYNC2_BYTE, 8'h11, 8'h22, 8'h05, 8'h00};
    push_bytes(directed);
    go_idle();
    program_max_length(16'd0);
    directed = '{8'h00, 8'h00};
    push_bytes(directed);
    run_random(250);

    program_max_length(16'hFFFF);
    run_random(300);

    send_idle_pct = 82;
    recv_idle_pct = 34;
    narrow_max = 16'($urandom_range(1, 40));
    program_max_length(narrow_max);
    run_random(600);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    wide_max = 16'($urandom_range(13, 65534));
    program_max_length(wide_max);
    run_random(600);

    sb.flush_missing();
    $display("Covered %0d rx bytes: %0d payload, %0d good CRC, %0d bad CRC, %0d oversize",
             sb.rx_bytes, sb.kind_count[slcfr_pkg::KIND_DATA],
             sb.kind_count[slcfr_pkg::KIND_GOOD],
             sb.kind_count[slcfr_pkg::KIND_BAD], sb.kind_count[slcfr_pkg::KIND_LONG]);
    $display("Length limits 4096, 0, 65535, %0d, %0d under three pacing modes",
             narrow_max, wide_max);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d failures", sb.failures);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
